// ----- src/nlsc_pkg.sv -----
`timescale 1ns / 1ps
// shared types, codes and constants of the length-prefix to start-code converter
// no dependencies; used by the result interface and every module of the block
package nlsc_pkg;

	// result kinds
	typedef enum logic [1:0] {
		KIND_BYTE   = 2'd0,
		KIND_STATUS = 2'd1,
		KIND_ERROR  = 2'd2
	} kind_t;

	// error codes
	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_ZERO_LEN = 2'd1,
		ERR_OVERRUN  = 2'd2,
		ERR_NO_NAL   = 2'd3
	} err_t;

	// parse phase
	typedef enum logic {
		PH_PREFIX  = 1'b0,
		PH_PAYLOAD = 1'b1
	} phase_t;

	localparam int NAL_COUNT_W  = 24;
	localparam int MAX_RESULTS  = 4;
	localparam logic [2:0] LEN_SIZE_RESET = 3'd4;

	// annex-b start code, entry 0 goes out first
	localparam logic [3:0][7:0] START_CODE = {8'h01, 8'h00, 8'h00, 8'h00};

	// one result item
	typedef struct packed {
		kind_t                   kind;
		logic [7:0]              out_byte;
		logic                    nal_end;
		err_t                    error_code;
		logic [NAL_COUNT_W-1:0]  nal_count;
		logic [1:0]              trailing_bytes;
		logic                    last;
	} res_t;

	// all results caused by one input byte
	typedef struct packed {
		logic [2:0]                  n;
		res_t [MAX_RESULTS-1:0]      r;
	} bundle_t;

	// build a result with last cleared
	function automatic res_t mk_res(kind_t k, logic [7:0] b, logic e, err_t c,
			logic [NAL_COUNT_W-1:0] cnt, logic [1:0] tr);
		res_t r;
		r.kind           = k;
		r.out_byte       = b;
		r.nal_end        = e;
		r.error_code     = c;
		r.nal_count      = cnt;
		r.trailing_bytes = tr;
		r.last           = 1'b0;
		return r;
	endfunction

endpackage

// ----- src/nlsc_if.sv -----
`timescale 1ns / 1ps
// valid/ready channel interfaces for sample bytes in and stream results out
// depends on nlsc_pkg for the result field widths
interface nlsc_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  sample_byte;
	logic [23:0] bytes_after;

	modport source (output valid, sample_byte, bytes_after, input ready);
	modport sink (input valid, sample_byte, bytes_after, output ready);
endinterface

interface nlsc_out_if;
	logic                              valid;
	logic                              ready;
	logic [1:0]                        kind;
	logic [7:0]                        out_byte;
	logic                              nal_end;
	logic [1:0]                        error_code;
	logic [nlsc_pkg::NAL_COUNT_W-1:0]  nal_count;
	logic [1:0]                        trailing_bytes;
	logic                              last;

	modport source (output valid, kind, out_byte, nal_end, error_code, nal_count,
		trailing_bytes, last, input ready);
	modport sink (input valid, kind, out_byte, nal_end, error_code, nal_count,
		trailing_bytes, last, output ready);
endinterface

// ----- src/nlsc_step.sv -----
`timescale 1ns / 1ps
// parser state and per-byte decision: turns one registered input byte into a
// bundle of up to four results; depends on nlsc_pkg
module nlsc_step #(
	parameter int AW = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s1_valid,
	input  logic [7:0]          s1_byte,
	input  logic [AW-1:0]       s1_after,
	input  logic [2:0]          length_size,
	input  logic                can_load,
	output logic                consume,
	output logic                load,
	output nlsc_pkg::bundle_t   bundle
);

	localparam logic [nlsc_pkg::NAL_COUNT_W-1:0] NAL_MAX = '1;

	nlsc_pkg::phase_t                  phase_q, phase_n;
	logic [1:0]                        pseen_q, pseen_n;
	logic [31:0]                       acc_q, acc_n;
	logic [AW-1:0]                     left_q, left_n;
	logic [nlsc_pkg::NAL_COUNT_W-1:0]  nals_q, nals_n;
	logic [1:0]                        trail_q, trail_n;
	logic                              halted_q, halted_n;

	logic [2:0]       ls;
	logic [2:0]       seen;
	logic [31:0]      acc_new;
	logic [AW-1:0]    left_dec;
	logic             short_prefix;
	logic             eos;
	logic [2:0]       eos_slot;
	logic [1:0]       last_idx;
	nlsc_pkg::bundle_t b;

	// prefix size clamped to 1..4
	always_comb begin
		if (length_size == 3'd0) begin
			ls = 3'd1;
		end else if (length_size > 3'd4) begin
			ls = 3'd4;
		end else begin
			ls = length_size;
		end
	end

	assign seen         = {1'b0, pseen_q} + 3'd1;
	assign acc_new      = {acc_q[23:0], s1_byte};
	assign left_dec     = left_q - AW'(1);
	assign short_prefix = ((AW+1)'(s1_after) + (AW+1)'(1)) < (AW+1)'(ls);

	// next state and results
	always_comb begin
		phase_n  = phase_q;
		pseen_n  = pseen_q;
		acc_n    = acc_q;
		left_n   = left_q;
		nals_n   = nals_q;
		trail_n  = trail_q;
		halted_n = halted_q;
		b        = '0;
		eos      = 1'b0;
		eos_slot = 3'd0;
		last_idx = 2'd0;
		if (!halted_q) begin
			case (phase_q)
				nlsc_pkg::PH_PAYLOAD: begin
					if (left_dec > s1_after) begin
						b.r[0] = nlsc_pkg::mk_res(nlsc_pkg::KIND_ERROR, 8'h00, 1'b0,
							nlsc_pkg::ERR_OVERRUN, '0, 2'd0);
						b.n = 3'd1;
						halted_n = 1'b1;
					end else begin
						left_n = left_dec;
						b.r[0] = nlsc_pkg::mk_res(nlsc_pkg::KIND_BYTE, s1_byte,
							left_dec == '0, nlsc_pkg::ERR_NONE, '0, 2'd0);
						b.n = 3'd1;
						if (left_dec == '0) begin
							phase_n = nlsc_pkg::PH_PREFIX;
							pseen_n = 2'd0;
							acc_n   = '0;
							if (s1_after == '0) begin
								eos      = 1'b1;
								eos_slot = 3'd1;
							end
						end
					end
				end
				nlsc_pkg::PH_PREFIX: begin
					if (pseen_q == 2'd0 && short_prefix) begin
						// too few bytes left for a prefix: drop and count
						if (trail_q != 2'd3) begin
							trail_n = trail_q + 2'd1;
						end
						if (s1_after == '0) begin
							eos      = 1'b1;
							eos_slot = 3'd0;
						end
					end else begin
						acc_n = acc_new;
						if (seen >= ls) begin
							if (acc_new == 32'd0) begin
								b.r[0] = nlsc_pkg::mk_res(nlsc_pkg::KIND_ERROR, 8'h00, 1'b0,
									nlsc_pkg::ERR_ZERO_LEN, '0, 2'd0);
								b.n = 3'd1;
								halted_n = 1'b1;
							end else if (acc_new > 32'(s1_after)) begin
								b.r[0] = nlsc_pkg::mk_res(nlsc_pkg::KIND_ERROR, 8'h00, 1'b0,
									nlsc_pkg::ERR_OVERRUN, '0, 2'd0);
								b.n = 3'd1;
								halted_n = 1'b1;
							end else begin
								// prefix replaced by the start code
								for (int i = 0; i < nlsc_pkg::MAX_RESULTS; i++) begin
									b.r[i] = nlsc_pkg::mk_res(nlsc_pkg::KIND_BYTE,
										nlsc_pkg::START_CODE[i], 1'b0, nlsc_pkg::ERR_NONE,
										'0, 2'd0);
								end
								b.n     = 3'd4;
								phase_n = nlsc_pkg::PH_PAYLOAD;
								left_n  = acc_new[AW-1:0];
								pseen_n = 2'd0;
								acc_n   = '0;
								if (nals_q != NAL_MAX) begin
									nals_n = nals_q + {{(nlsc_pkg::NAL_COUNT_W-1){1'b0}}, 1'b1};
								end
							end
						end else if (s1_after == '0) begin
							// sample ends inside a prefix
							b.r[0] = nlsc_pkg::mk_res(nlsc_pkg::KIND_ERROR, 8'h00, 1'b0,
								nlsc_pkg::ERR_OVERRUN, '0, 2'd0);
							b.n = 3'd1;
							halted_n = 1'b1;
						end else begin
							pseen_n = seen[1:0];
						end
					end
				end
				default: begin
					phase_n = nlsc_pkg::PH_PREFIX;
				end
			endcase

			// end of sample: status or no-nal error
			if (eos) begin
				if (nals_q == '0) begin
					b.r[eos_slot[1:0]] = nlsc_pkg::mk_res(nlsc_pkg::KIND_ERROR, 8'h00, 1'b0,
						nlsc_pkg::ERR_NO_NAL, '0, 2'd0);
					halted_n = 1'b1;
				end else begin
					b.r[eos_slot[1:0]] = nlsc_pkg::mk_res(nlsc_pkg::KIND_STATUS, 8'h00, 1'b0,
						nlsc_pkg::ERR_NONE, nals_q, trail_n);
					nals_n  = '0;
					trail_n = 2'd0;
				end
				b.n = eos_slot + 3'd1;
			end

			// mark the final result of this byte
			if (b.n != 3'd0) begin
				last_idx = 2'(b.n - 3'd1);
				b.r[last_idx].last = 1'b1;
			end
		end
	end

	assign bundle  = b;
	assign consume = s1_valid && (b.n == 3'd0 || can_load);
	assign load    = consume && (b.n != 3'd0);

	// parser state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= nlsc_pkg::PH_PREFIX;
			pseen_q  <= 2'd0;
			acc_q    <= '0;
			left_q   <= '0;
			nals_q   <= '0;
			trail_q  <= 2'd0;
			halted_q <= 1'b0;
		end else if (consume) begin
			phase_q  <= phase_n;
			pseen_q  <= pseen_n;
			acc_q    <= acc_n;
			left_q   <= left_n;
			nals_q   <= nals_n;
			trail_q  <= trail_n;
			halted_q <= halted_n;
		end
	end

endmodule

// ----- src/nlsc_emit.sv -----
`timescale 1ns / 1ps
// result register: holds the bundle of one byte and shifts it out one result
// per output transfer; depends on nlsc_pkg
module nlsc_emit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  nlsc_pkg::bundle_t  bundle,
	output logic               can_load,
	output logic               out_valid,
	input  logic               out_ready,
	output nlsc_pkg::res_t     out_res
);

	nlsc_pkg::res_t [nlsc_pkg::MAX_RESULTS-1:0] ent_q, ent_shift;
	logic [2:0] cnt_q;
	logic       xfer;

	assign out_valid = cnt_q != 3'd0;
	assign out_res   = ent_q[0];
	assign xfer      = out_valid && out_ready;
	assign can_load  = (cnt_q == 3'd0) || (cnt_q == 3'd1 && out_ready);

	// entries moved down by one
	always_comb begin
		for (int i = 0; i < nlsc_pkg::MAX_RESULTS - 1; i++) begin
			ent_shift[i] = ent_q[i+1];
		end
		ent_shift[nlsc_pkg::MAX_RESULTS-1] = '0;
	end

	// occupancy count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else if (load) begin
			cnt_q <= bundle.n;
		end else if (xfer) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	// result entries
	always_ff @(posedge clk) begin
		if (load) begin
			ent_q <= bundle.r;
		end else if (xfer) begin
			ent_q <= ent_shift;
		end
	end

endmodule

// ----- src/nal_length_prefix_to_start_code.sv -----
`timescale 1ns / 1ps
// Length-prefixed NAL sample to Annex-B stream converter, top level.
// Channels: sample_in carries one sample byte with the count of sample bytes
// after it; result_out carries stream bytes, end-of-sample status and errors,
// with last set on the final result of each input byte. Both are valid/ready,
// a transfer happens at a clock edge with valid and ready high. cfg_we and
// cfg_data write length_size (prefix bytes, 1..4); the user must write it only
// while the block is idle, the block does not enforce this. A byte taken on
// sample_in sits in the input register, is parsed and loaded into the result
// register, and its results leave from there. Throughput: one input byte per
// cycle while each byte gives one result and result_out is ready; the byte
// that completes a prefix gives four start-code results and holds the input
// while the result register sends them, one result per cycle.
// Reset: length_size returns to 4, the parser returns to the prefix phase with
// all counts cleared and any halt after an error released.
// Stall: when result_out is not ready the result register holds, the input
// register fills and sample_in.ready drops; nothing is lost.
// Depends on nlsc_pkg, nlsc_if, nlsc_step and nlsc_emit.
module nal_length_prefix_to_start_code #(
	parameter int SAMPLE_SIZE_BITS = 24
) (
	input  logic            clk,
	input  logic            arst_n,
	nlsc_in_if.sink         sample_in,
	nlsc_out_if.source      result_out,
	input  logic            cfg_we,
	input  logic [2:0]      cfg_data
);

	localparam int AW = (SAMPLE_SIZE_BITS < 24) ? SAMPLE_SIZE_BITS : 24;

	logic [2:0]        length_size_q;
	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic [AW-1:0]     after_s1;
	logic              consume;
	logic              load;
	logic              can_load;
	nlsc_pkg::bundle_t bundle;
	nlsc_pkg::res_t    res;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_size_q <= nlsc_pkg::LEN_SIZE_RESET;
		end else if (cfg_we) begin
			length_size_q <= cfg_data;
		end
	end

	// input register
	assign sample_in.ready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_in.ready) begin
			valid_s1 <= sample_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_in.ready && sample_in.valid) begin
			byte_s1  <= sample_in.sample_byte;
			after_s1 <= sample_in.bytes_after[AW-1:0];
		end
	end

	// parser
	nlsc_step #(
		.AW (AW)
	) u_step (
		.clk         (clk),
		.arst_n      (arst_n),
		.s1_valid    (valid_s1),
		.s1_byte     (byte_s1),
		.s1_after    (after_s1),
		.length_size (length_size_q),
		.can_load    (can_load),
		.consume     (consume),
		.load        (load),
		.bundle      (bundle)
	);

	// result register
	nlsc_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.bundle    (bundle),
		.can_load  (can_load),
		.out_valid (result_out.valid),
		.out_ready (result_out.ready),
		.out_res   (res)
	);

	// result fields
	assign result_out.kind           = res.kind;
	assign result_out.out_byte       = res.out_byte;
	assign result_out.nal_end        = res.nal_end;
	assign result_out.error_code     = res.error_code;
	assign result_out.nal_count      = res.nal_count;
	assign result_out.trailing_bytes = res.trailing_bytes;
	assign result_out.last           = res.last;

`ifndef ASSERT_OFF
	// an error is the final result: nothing follows it
	a_error_halts: assert property (@(posedge clk) disable iff (!arst_n)
		result_out.valid && result_out.ready && result_out.kind == nlsc_pkg::KIND_ERROR
		|=> !result_out.valid)
		else $error("result after an error transfer");

	// a status report always counts at least one nal unit
	a_status_count: assert property (@(posedge clk) disable iff (!arst_n)
		result_out.valid && result_out.kind == nlsc_pkg::KIND_STATUS
		|-> result_out.nal_count != '0)
		else $error("status with zero nal count");

	// a parked input byte stays in the input register
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !consume |=> valid_s1 && $stable(byte_s1))
		else $error("input register lost a waiting byte");
`endif

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// self-checking testbench for nal_length_prefix_to_start_code: drives length-prefixed
// samples, predicts the annex-b stream, status and error results, and checks each transfer
// depends on nlsc_pkg, nlsc_if and the converter top level
module testbench;

	localparam int LIMIT_CYCLES = 200000;
	localparam int DRAIN_CYCLES = 6;
	localparam int LONG_HOLD    = 40;
	localparam int PHASE_BYTES  = 1;

	// ways to break the stream at the close of the run
	typedef enum int {
		BRK_ZERO_LEN,
		BRK_LEN_OVERRUN,
		BRK_PREFIX_CUT,
		BRK_PAYLOAD_OVERRUN,
		BRK_NO_NAL
	} broken_t;

	typedef struct {
		logic [7:0]  data;
		logic [23:0] after;
	} in_byte_t;

	// annex-b predictor and store of the results still owed by the block
	class annexb_scoreboard;
		logic [2:0]        length_size;
		nlsc_pkg::phase_t  phase;
		logic [1:0]        prefix_seen;
		logic [31:0]       length_acc;
		logic [31:0]       payload_left;
		logic [23:0]       nal_count;
		logic [1:0]        trail_count;
		bit                halted;
		nlsc_pkg::res_t    owed_results[$];
		int                mismatches;
		int                results_seen;

		function new();
			length_size  = nlsc_pkg::LEN_SIZE_RESET;
			phase        = nlsc_pkg::PH_PREFIX;
			prefix_seen  = '0;
			length_acc   = '0;
			payload_left = '0;
			nal_count    = '0;
			trail_count  = '0;
			halted       = 1'b0;
			mismatches   = 0;
			results_seen = 0;
		endfunction

		function void set_length_size(logic [2:0] v);
			length_size = v;
		endfunction

		function void push_result(nlsc_pkg::kind_t k, logic [7:0] b, logic e,
				nlsc_pkg::err_t c, logic [23:0] cnt, logic [1:0] tr);
			nlsc_pkg::res_t r;
			r.kind           = k;
			r.out_byte       = b;
			r.nal_end        = e;
			r.error_code     = c;
			r.nal_count      = cnt;
			r.trailing_bytes = tr;
			r.last           = 1'b0;
			owed_results.push_back(r);
		endfunction

		function void raise_error(nlsc_pkg::err_t c);
			halted = 1'b1;
			push_result(nlsc_pkg::KIND_ERROR, 8'h00, 1'b0, c, '0, '0);
		endfunction

		function void close_sample();
			if (nal_count == 0) begin
				raise_error(nlsc_pkg::ERR_NO_NAL);
			end else begin
				push_result(nlsc_pkg::KIND_STATUS, 8'h00, 1'b0, nlsc_pkg::ERR_NONE,
					nal_count, trail_count);
				nal_count   = '0;
				trail_count = '0;
			end
		endfunction

		// work out the results of one accepted sample byte
		function void note_byte(logic [7:0] b, logic [23:0] after);
			int             base;
			int             eff;
			int             seen;
			nlsc_pkg::res_t tail;
			base = owed_results.size();
			if (halted) return;
			eff = (length_size < 1) ? 1 : (length_size > 4) ? 4 : int'(length_size);
			if (phase == nlsc_pkg::PH_PAYLOAD) begin
				// more payload owed than the sample still holds
				if ({1'b0, payload_left} - 33'd1 > {9'd0, after}) begin
					raise_error(nlsc_pkg::ERR_OVERRUN);
				end else begin
					payload_left = payload_left - 32'd1;
					push_result(nlsc_pkg::KIND_BYTE, b, payload_left == 0, nlsc_pkg::ERR_NONE,
						'0, '0);
					if (payload_left == 0) begin
						phase       = nlsc_pkg::PH_PREFIX;
						prefix_seen = '0;
						length_acc  = '0;
						if (after == 0) close_sample();
					end
				end
			end else if (prefix_seen == 0 && int'(after) + 1 < eff) begin
				// too few bytes left for a prefix: drop and count
				if (trail_count < 3) trail_count = trail_count + 2'd1;
				if (after == 0) close_sample();
			end else begin
				seen       = int'(prefix_seen) + 1;
				length_acc = {length_acc[23:0], b};
				if (seen >= eff) begin
					if (length_acc == 0) begin
						raise_error(nlsc_pkg::ERR_ZERO_LEN);
					end else if (length_acc > {8'd0, after}) begin
						raise_error(nlsc_pkg::ERR_OVERRUN);
					end else begin
						for (int i = 0; i < 4; i++)
							push_result(nlsc_pkg::KIND_BYTE, nlsc_pkg::START_CODE[i], 1'b0,
								nlsc_pkg::ERR_NONE, '0, '0);
						phase        = nlsc_pkg::PH_PAYLOAD;
						payload_left = length_acc;
						prefix_seen  = '0;
						length_acc   = '0;
						if (nal_count != {24{1'b1}}) nal_count = nal_count + 24'd1;
					end
				end else if (after == 0) begin
					raise_error(nlsc_pkg::ERR_OVERRUN);
				end else begin
					prefix_seen = seen[1:0];
				end
			end
			// mark the final result of this byte
			if (owed_results.size() > base) begin
				tail      = owed_results.pop_back();
				tail.last = 1'b1;
				owed_results.push_back(tail);
			end
		endfunction

		function void check_result(nlsc_pkg::res_t got);
			nlsc_pkg::res_t want;
			results_seen++;
			if (owed_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"unexpected result: kind %0d byte %02h end %0d err %0d",
						" count %0d trail %0d last %0d"},
						got.kind, got.out_byte, got.nal_end, got.error_code,
						got.nal_count, got.trailing_bytes, got.last);
				return;
			end
			want = owed_results.pop_front();
			if (got.kind !== want.kind || got.out_byte !== want.out_byte ||
					got.nal_end !== want.nal_end || got.error_code !== want.error_code ||
					got.nal_count !== want.nal_count ||
					got.trailing_bytes !== want.trailing_bytes || got.last !== want.last) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display({"mismatch: expected kind %0d byte %02h end %0d err %0d",
						" count %0d trail %0d last %0d"},
						want.kind, want.out_byte, want.nal_end, want.error_code,
						want.nal_count, want.trailing_bytes, want.last);
					$display({"          actual   kind %0d byte %02h end %0d err %0d",
						" count %0d trail %0d last %0d"},
						got.kind, got.out_byte, got.nal_end, got.error_code,
						got.nal_count, got.trailing_bytes, got.last);
				end
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [2:0] cfg_data;

	nlsc_in_if  sample_if();
	nlsc_out_if result_if();

	annexb_scoreboard sb = new();

	int       send_idle_pct = 0;
	int       recv_stall_pct = 0;
	int       hold_req_count = 0;
	int       bytes_sent = 0;
	int       settings_used = 0;
	int       cycle_count = 0;
	in_byte_t pending_bytes[$];

	nal_length_prefix_to_start_code dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample_in  (sample_if),
		.result_out (result_if),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data)
	);

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	// receiver: random stalls plus a long hold-off on request
	always @(posedge clk) begin : receiver
		int hold_left;
		int hold_taken;
		if (hold_req_count != hold_taken) begin
			hold_taken = hold_req_count;
			hold_left  = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_if.ready <= 1'b0;
		end else begin
			result_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// result monitor: check every output transfer
	always @(posedge clk) begin : result_monitor
		nlsc_pkg::res_t got;
		if (arst_n && result_if.valid && result_if.ready) begin
			got.kind           = nlsc_pkg::kind_t'(result_if.kind);
			got.out_byte       = result_if.out_byte;
			got.nal_end        = result_if.nal_end;
			got.error_code     = nlsc_pkg::err_t'(result_if.error_code);
			got.nal_count      = result_if.nal_count;
			got.trailing_bytes = result_if.trailing_bytes;
			got.last           = result_if.last;
			sb.check_result(got);
		end
	end

	function automatic int effective_size(logic [2:0] v);
		return (v < 1) ? 1 : (v > 4) ? 4 : int'(v);
	endfunction

	function automatic void queue_byte(logic [7:0] d, logic [23:0] a);
		in_byte_t it;
		it.data  = d;
		it.after = a;
		pending_bytes.push_back(it);
	endfunction

	// offer one byte, with random idle cycles ahead of it
	task automatic send_byte(logic [7:0] d, logic [23:0] a);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			sample_if.valid <= 1'b0;
			@(posedge clk);
		end
		sample_if.valid       <= 1'b1;
		sample_if.sample_byte <= d;
		sample_if.bytes_after <= a;
		@(posedge clk);
		while (!sample_if.ready) @(posedge clk);
		sb.note_byte(d, a);
		bytes_sent++;
	endtask

	task automatic send_queued();
		in_byte_t it;
		while (pending_bytes.size() > 0) begin
			it = pending_bytes.pop_front();
			send_byte(it.data, it.after);
		end
	endtask

	// stop offering and wait for every owed result
	task automatic wait_for_results();
		sample_if.valid <= 1'b0;
		do @(posedge clk); while (sb.owed_results.size() != 0);
	endtask

	task automatic write_length_size(logic [2:0] v);
		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_length_size(v);
		settings_used++;
	endtask

	// queue one well-formed sample with random content, junk and trailing bytes
	task automatic build_sample(int eff);
		logic [7:0] body[$];
		bit         fixed[$];
		logic [23:0] fixed_after[$];
		int         n_nal;
		int         len;
		int         n_trail;
		int         total;
		int         true_after;
		bit         noisy;
		logic [23:0] a;
		n_nal = $urandom_range(1, 2);
		noisy = ($urandom_range(0, 3) == 0);
		for (int k = 0; k < n_nal; k++) begin
			// a dropped byte in front of a prefix, with a short count
			if (eff >= 3 && $urandom_range(0, 5) == 0) begin
				body.push_back(8'($urandom_range(0, 255)));
				fixed.push_back(1'b1);
				fixed_after.push_back(24'($urandom_range(1, eff - 2)));
			end
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 6);
			for (int j = 0; j < eff; j++) begin
				body.push_back(8'(len >> (8 * (eff - 1 - j))));
				fixed.push_back(1'b0);
				fixed_after.push_back('0);
			end
			for (int j = 0; j < len; j++) begin
				body.push_back(8'($urandom_range(0, 255)));
				fixed.push_back(1'b0);
				fixed_after.push_back('0);
			end
		end
		n_trail = $urandom_range(0, eff - 1);
		for (int j = 0; j < n_trail; j++) begin
			body.push_back(8'($urandom_range(0, 255)));
			fixed.push_back(1'b0);
			fixed_after.push_back('0);
		end
		total = body.size();
		for (int i = 0; i < total; i++) begin
			true_after = total - i - 1;
			if (fixed[i]) a = fixed_after[i];
			else if (noisy && true_after >= 4) a = 24'(true_after) | (24'($urandom) & 24'hFFFF00);
			else a = 24'(true_after);
			queue_byte(body[i], a);
		end
	endtask

	task automatic run_phase(logic [2:0] ls, int send_pct, int recv_pct, bit with_hold,
			bit with_pause);
		int start;
		bit paused;
		write_length_size(ls);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		if (with_hold) hold_req_count++;
		start  = bytes_sent;
		paused = 1'b0;
		while (bytes_sent - start < PHASE_BYTES) begin
			build_sample(effective_size(ls));
			send_queued();
			if (with_pause && !paused && bytes_sent - start >= PHASE_BYTES / 2) begin
				wait_for_results();
				paused = 1'b1;
			end
		end
	endtask

	initial begin : stimulus
		broken_t     broken;
		logic [2:0]  ls;
		int          eff;
		logic [23:0] len;
		arst_n                <= 1'b0;
		cfg_we                <= 1'b0;
		cfg_data              <= '0;
		sample_if.valid       <= 1'b0;
		sample_if.sample_byte <= '0;
		sample_if.bytes_after <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset length size of four, extreme byte counts trusted as given
		queue_byte(8'h00, 24'hFFFFFF);
		queue_byte(8'h00, 24'd4);
		queue_byte(8'h00, 24'd3);
		queue_byte(8'h02, 24'd2);
		queue_byte(8'hFF, 24'hFFFFFF);
		queue_byte(8'h00, 24'd0);
		// trailing count saturates on a run of short-count bytes
		queue_byte(8'h00, 24'd10);
		queue_byte(8'h00, 24'd9);
		queue_byte(8'h00, 24'd8);
		queue_byte(8'h01, 24'd7);
		queue_byte(8'hAB, 24'd6);
		queue_byte(8'h11, 24'd1);
		queue_byte(8'h22, 24'd1);
		queue_byte(8'h33, 24'd1);
		queue_byte(8'h44, 24'd1);
		queue_byte(8'h55, 24'd0);
		send_queued();
		// length size zero acts as one
		write_length_size(3'd0);
		queue_byte(8'h01, 24'd4);
		queue_byte(8'h55, 24'd3);
		queue_byte(8'h02, 24'd2);
		queue_byte(8'hAA, 24'd1);
		queue_byte(8'hBB, 24'd0);
		send_queued();

		// random well-formed samples over several settings and idle patterns
		run_phase(3'd2, 0, 0, 1'b1, 1'b0);
		run_phase(3'd7, 85, 0, 1'b0, 1'b0);
		run_phase(3'd1, 0, 85, 1'b0, 1'b0);
		run_phase(3'd3, 21, 21, 1'b0, 1'b1);
		run_phase(3'd5, 0, 0, 1'b0, 1'b0);
		run_phase(3'd6, 85, 85, 1'b0, 1'b0);
		run_phase(3'd4, 21, 21, 1'b0, 1'b0);

		// one well-formed sample, then a fatal broken one, then ignored bytes
		broken = broken_t'($urandom_range(0, 4));
		case (broken)
			BRK_PREFIX_CUT: ls = 3'($urandom_range(3, 7));
			BRK_NO_NAL:     ls = 3'($urandom_range(2, 7));
			default:        ls = 3'($urandom_range(0, 7));
		endcase
		eff = effective_size(ls);
		write_length_size(ls);
		build_sample(eff);
		case (broken)
			BRK_ZERO_LEN: begin
				for (int j = 0; j < eff; j++) queue_byte(8'h00, 24'(eff - 1 - j + 8));
			end
			BRK_LEN_OVERRUN: begin
				len = 24'($urandom) & 24'h7FFFFF;
				if (eff < 3) len = len & ((24'd1 << (8 * eff)) - 24'd1);
				if (len < 2) len = 24'd2;
				for (int j = 0; j < eff; j++)
					queue_byte(8'(len >> (8 * (eff - 1 - j))), len - 24'd1 + 24'(eff - 1 - j));
			end
			BRK_PREFIX_CUT: begin
				queue_byte(8'($urandom_range(0, 255)), 24'($urandom_range(5, 100)));
				queue_byte(8'($urandom_range(0, 255)), 24'd0);
			end
			BRK_PAYLOAD_OVERRUN: begin
				for (int j = 0; j < eff; j++)
					queue_byte(8'(3 >> (8 * (eff - 1 - j))), 24'(eff - 1 - j + 3));
				queue_byte(8'($urandom_range(0, 255)), 24'd0);
			end
			default: begin
				queue_byte(8'($urandom_range(0, 255)), 24'd0);
			end
		endcase
		for (int j = 0; j < 3; j++) queue_byte(8'($urandom_range(0, 255)), 24'($urandom));
		send_queued();

		wait_for_results();
		repeat (DRAIN_CYCLES * 2) @(posedge clk);
		$display("covered %0d sample bytes and %0d results over %0d length-size writes",
			bytes_sent, sb.results_seen, settings_used);
		$display("closing broken sample: %s at length size %0d, mismatches %0d",
			broken.name(), ls, sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule
